// ----- design/mbcrc_pkg.sv -----
// ---------------------------------------------------------------------------
// mbcrc_pkg: shared types and CRC helper for the Modbus frame CRC block
// Result word layout, result kinds, frame status codes and the byte fold.
// ---------------------------------------------------------------------------
package mbcrc_pkg;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  FrameLenRst  = 8'd52;
  localparam logic [7:0]  ByteCountMax = 8'hFF;
  localparam logic [7:0]  MinRxLen     = 8'd2;

  // Number of result words one input word can cause
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  typedef enum logic [0:0] {
    OP_TX = 1'b0,
    OP_RX = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CRC_LO = 2'd1,
    KIND_CRC_HI = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SHORT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    status_e    status;
    logic       last;
  } result_t;

  // Group of results produced by one input word, entry 0 delivered first
  typedef struct packed {
    logic [ResCntW-1:0]       cnt;
    result_t [MaxRes-1:0]     res;
  } bundle_t;

  // Reflected CRC-16 fold of one byte, low bit first (eight XOR steps)
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/mbcrc_core.sv -----
// ---------------------------------------------------------------------------
// mbcrc_core: input register, frame state and result computation
// Holds one input word, folds it into the frame state and forms its results.
// ---------------------------------------------------------------------------
module mbcrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                can_load_i,
  output logic                load_o,
  output mbcrc_pkg::bundle_t  bundle_o
);

  logic       in_valid_q;
  logic       op_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;

  logic [7:0]  max_len_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [7:0]  count_q, count_d;
  logic        ovf_q, ovf_d;

  logic [15:0] crc_tx, crc_rx;
  logic [7:0]  count_inc;
  logic        ovf_rx;
  mbcrc_pkg::status_e   st;
  mbcrc_pkg::result_t   blank;

  assign advance    = in_valid_q && can_load_i;
  assign in_ready_o = !in_valid_q || advance;
  assign load_o     = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mbcrc_pkg::FrameLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= mbcrc_pkg::CrcInit;
      held0_q <= '0;
      held1_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (advance) begin
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    crc_tx = mbcrc_pkg::crc_fold(crc_q, byte_q);
    // receive path folds the oldest held byte once two are waiting
    crc_rx = (count_q >= mbcrc_pkg::MinRxLen) ? mbcrc_pkg::crc_fold(crc_q, held0_q)
                                              : crc_q;
    count_inc = (count_q == mbcrc_pkg::ByteCountMax) ? count_q : count_q + 8'd1;
    ovf_rx    = ovf_q || (count_inc >= max_len_q);

    if (ovf_rx) begin
      st = mbcrc_pkg::ST_OVERFLOW;
    end else if (count_inc < mbcrc_pkg::MinRxLen) begin
      st = mbcrc_pkg::ST_SHORT;
    end else if (held1_q == crc_rx[7:0] && byte_q == crc_rx[15:8]) begin
      st = mbcrc_pkg::ST_OK;
    end else begin
      st = mbcrc_pkg::ST_MISMATCH;
    end

    blank = '{out_byte: 8'h00, kind: mbcrc_pkg::KIND_DATA,
              status: mbcrc_pkg::ST_OK, last: 1'b0};
    bundle_o.res = {blank, blank, blank};
    bundle_o.cnt = '0;

    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    count_d = count_q;
    ovf_d   = ovf_q;

    if (op_q == mbcrc_pkg::OP_TX) begin
      bundle_o.res[0] = '{out_byte: byte_q, kind: mbcrc_pkg::KIND_DATA,
                          status: mbcrc_pkg::ST_OK, last: 1'b0};
      crc_d = crc_tx;
      if (last_q) begin
        bundle_o.res[1] = '{out_byte: crc_tx[7:0], kind: mbcrc_pkg::KIND_CRC_LO,
                            status: mbcrc_pkg::ST_OK, last: 1'b0};
        bundle_o.res[2] = '{out_byte: crc_tx[15:8], kind: mbcrc_pkg::KIND_CRC_HI,
                            status: mbcrc_pkg::ST_OK, last: 1'b1};
        bundle_o.cnt = mbcrc_pkg::ResCntW'(3);
      end else begin
        bundle_o.cnt = mbcrc_pkg::ResCntW'(1);
      end
    end else begin
      crc_d   = crc_rx;
      held0_d = held1_q;
      held1_d = byte_q;
      count_d = count_inc;
      ovf_d   = ovf_rx;
      if (last_q) begin
        bundle_o.res[0] = '{out_byte: 8'h00, kind: mbcrc_pkg::KIND_STATUS,
                            status: st, last: 1'b1};
        bundle_o.cnt = mbcrc_pkg::ResCntW'(1);
      end
    end

    // any last byte closes the frame
    if (last_q) begin
      crc_d   = mbcrc_pkg::CrcInit;
      held0_d = '0;
      held1_d = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

endmodule

// ----- design/mbcrc_out.sv -----
// ---------------------------------------------------------------------------
// mbcrc_out: result register and serialiser
// Holds up to three result words and hands them out one per ready cycle.
// ---------------------------------------------------------------------------
module mbcrc_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mbcrc_pkg::bundle_t  bundle_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbcrc_pkg::result_t  head_o
);

  logic [mbcrc_pkg::ResCntW-1:0]          cnt_q;
  mbcrc_pkg::result_t [mbcrc_pkg::MaxRes-1:0] res_q;
  logic                                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // free now, or the single remaining word leaves this cycle
  assign can_load_o  = (cnt_q == '0) ||
                       (cnt_q == mbcrc_pkg::ResCntW'(1) && out_ready_i);
  assign head_o      = res_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - mbcrc_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end else if (pop) begin
      for (int k = 0; k < mbcrc_pkg::MaxRes - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
    end
  end

endmodule

// ----- design/modbus_frame_crc_append_check.sv -----
// ---------------------------------------------------------------------------
// modbus_frame_crc_append_check: CRC-16/MODBUS frame append and check
// Transmit words pass through with the CRC appended; receive frames checked.
// ---------------------------------------------------------------------------
// Usage notes
//  - Input channel (in_valid_i/in_ready_o): one byte word per handshake,
//    op_i selects transmit (0) or receive (1), last_byte_i closes a frame.
//  - Output channel (out_valid_o/out_ready_i): one result word per handshake.
//    A transmit word gives its data word, plus CRC low and CRC high words
//    when it is the last byte. A receive word gives nothing, or one status
//    word on the last byte (ok, mismatch, overflow, too short).
//  - Order: an accepted word is held in the input register, then its
//    results move to the result register, whose head drives the output.
//  - Throughput: one input word per cycle while each word yields at most
//    one result and out_ready_i stays high; a transmit last byte holds the
//    input while its three results drain through the single output port.
//  - cfg_we_i/cfg_wdata_i write max_frame_len; write only while idle.
//  - Reset (rst_ni low, async) empties both registers, returns the CRC to
//    0xFFFF, clears the frame state and sets max_frame_len to 52.
//  - Receiver stall: results wait in the result register; the input
//    register keeps one more word, then in_ready_o drops until space frees.
// ---------------------------------------------------------------------------
module modbus_frame_crc_append_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic [1:0] frame_status_o,
  output logic       last_out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic               load;
  logic               can_load;
  mbcrc_pkg::bundle_t bundle;
  mbcrc_pkg::result_t head;

  // input register, frame state and result forming
  mbcrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .can_load_i  (can_load),
    .load_o      (load),
    .bundle_o    (bundle)
  );

  // result register, drains one word a cycle while out_ready_i is high
  mbcrc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_byte_o     = head.out_byte;
  assign out_kind_o     = head.kind;
  assign frame_status_o = head.status;
  assign last_out_o     = head.last;

endmodule

// ----- tb/sv/modbus_frame_crc_append_check_tb.sv -----
// ---------------------------------------------------------------------------
// modbus_frame_crc_append_check_tb: self-checking bench for the CRC framer
// Drives transmit and receive frames through the valid/ready ports, predicts
// every result word with a cycle-free model and compares in arrival order.
// ---------------------------------------------------------------------------
module modbus_frame_crc_append_check_tb;

  // Longest legal quiet spell is the receiver hold-off (HoldOffLen); the
  // watchdog allows QuietLimit, far above it, before declaring the block hung.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldOffLen = 200;
  localparam int unsigned PhaseWords = 22;

  // -------------------------------------------------------------------------
  // Framer prediction and result store
  // -------------------------------------------------------------------------
  class crc_framer_model;
    logic [7:0]           max_len;
    logic [15:0]          crc;
    logic [7:0]           held [2];
    logic [7:0]           count;
    bit                   ovf;
    mbcrc_pkg::result_t   exp_q[$];
    int                   errors;

    function new();
      max_len = mbcrc_pkg::FrameLenRst;
      errors  = 0;
      clear_frame();
    endfunction

    // Reflected CRC-16, one byte, lsb first
    static function logic [15:0] fold_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      repeat (8) v = v[0] ? ((v >> 1) ^ mbcrc_pkg::CrcPoly) : (v >> 1);
      return v;
    endfunction

    function void clear_frame();
      crc     = mbcrc_pkg::CrcInit;
      held[0] = 8'h00;
      held[1] = 8'h00;
      count   = 8'h00;
      ovf     = 1'b0;
    endfunction

    function void queue_result(logic [7:0] b, mbcrc_pkg::kind_e k,
                               mbcrc_pkg::status_e s, logic l);
      mbcrc_pkg::result_t r;
      r.out_byte = b;
      r.kind     = k;
      r.status   = s;
      r.last     = l;
      exp_q.push_back(r);
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    // Called for every accepted input word
    function void take_word(mbcrc_pkg::op_e op, logic [7:0] b, logic last);
      mbcrc_pkg::status_e st;
      if (op == mbcrc_pkg::OP_TX) begin
        crc = fold_byte(crc, b);
        queue_result(b, mbcrc_pkg::KIND_DATA, mbcrc_pkg::ST_OK, 1'b0);
        if (last) begin
          queue_result(crc[7:0], mbcrc_pkg::KIND_CRC_LO, mbcrc_pkg::ST_OK, 1'b0);
          queue_result(crc[15:8], mbcrc_pkg::KIND_CRC_HI, mbcrc_pkg::ST_OK, 1'b1);
          clear_frame();
        end
      end else begin
        // Oldest held byte leaves the delay line into the CRC
        if (count >= 8'd2) crc = fold_byte(crc, held[0]);
        held[0] = held[1];
        held[1] = b;
        if (count != mbcrc_pkg::ByteCountMax) count++;
        if (count >= max_len) ovf = 1'b1;
        if (last) begin
          if (ovf) st = mbcrc_pkg::ST_OVERFLOW;
          else if (count < mbcrc_pkg::MinRxLen) st = mbcrc_pkg::ST_SHORT;
          else if (held[0] == crc[7:0] && held[1] == crc[15:8]) st = mbcrc_pkg::ST_OK;
          else st = mbcrc_pkg::ST_MISMATCH;
          queue_result(8'h00, mbcrc_pkg::KIND_STATUS, st, 1'b1);
          clear_frame();
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    // Called for every accepted result word
    task check_word(logic [7:0] b, logic [1:0] k, logic [1:0] s, logic l);
      mbcrc_pkg::result_t e;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected word byte=%h kind=%0d st=%0d last=%b", b, k, s, l));
      end else begin
        e = exp_q.pop_front();
        if (b !== e.out_byte || k !== e.kind || s !== e.status || l !== e.last)
          report($sformatf("got byte=%h kind=%0d st=%0d last=%b, want %h/%0d/%0d/%b",
                           b, k, s, l, e.out_byte, e.kind, e.status, e.last));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Block under test; every input known from time zero
  // -------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] out_kind_o;
  logic [1:0] frame_status_o;
  logic       last_out_o;

  modbus_frame_crc_append_check dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_kind_o     (out_kind_o),
    .frame_status_o (frame_status_o),
    .last_out_o     (last_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  crc_framer_model framer = new();

  // Idling knobs, percent of cycles; set by the main sequence per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned quiet = 0;

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request. The hold-off
  // is counted here so the sender keeps offering words meanwhile.
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffLen;
    end
    if (hold_left != 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: sampled on the rising edge, payload stable since negedge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      framer.check_word(out_byte_o, out_kind_o, frame_status_o, last_out_o);
  end

  // Watchdog: any handshake on either side counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("[modbus_frame_crc_append_check] ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks
  // -------------------------------------------------------------------------

  // Offer one word; idle gaps are taken before valid rises, never after
  task automatic send_word(mbcrc_pkg::op_e op, logic [7:0] b, bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    op_i        = op;
    data_byte_i = b;
    last_byte_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    framer.take_word(op, b, last);
    words_sent++;
  endtask

  task automatic send_tx_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_word(mbcrc_pkg::OP_TX, 8'($urandom), i == len - 1);
  endtask

  // Receive frame with its CRC appended, low byte first; optionally one bit
  // flipped anywhere in the frame so the check must fail.
  task automatic send_rx_frame(int unsigned payload_len, bit corrupt);
    logic [15:0] c;
    logic [7:0]  b;
    logic [7:0]  frame_bytes[$];
    int unsigned flip;
    c = mbcrc_pkg::CrcInit;
    for (int unsigned i = 0; i < payload_len; i++) begin
      b = 8'($urandom);
      frame_bytes.push_back(b);
      c = crc_framer_model::fold_byte(c, b);
    end
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    if (corrupt) begin
      flip = $urandom_range(frame_bytes.size() - 1);
      frame_bytes[flip] ^= 8'(1 << $urandom_range(7));
    end
    foreach (frame_bytes[i])
      send_word(mbcrc_pkg::OP_RX, frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid, wait out every expected word, then cover the pipeline depth
  // (input register + result register) for receive words with no result.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (framer.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [7:0] v);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    framer.max_len = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random traffic: mostly well-formed frames with random content, some
  // broken, short, over-length and loose noise words mixed in.
  task automatic run_random(int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned total;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_rx_frame(($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(8), 1'b0);
      end else if (pick < 70) begin
        send_tx_frame($urandom_range(1, 8));
      end else if (pick < 80) begin
        send_rx_frame($urandom_range(6), 1'b1);
      end else if (pick < 87) begin
        // one or two bytes only: too short, or a bare two-byte check
        if ($urandom_range(1)) begin
          send_word(mbcrc_pkg::OP_RX, 8'($urandom), 1'b1);
        end else begin
          send_word(mbcrc_pkg::OP_RX, 8'($urandom), 1'b0);
          send_word(mbcrc_pkg::OP_RX, 8'($urandom), 1'b1);
        end
      end else if (pick < 93 && framer.max_len <= 40) begin
        // frame length straddling the overflow threshold
        total = $urandom_range(framer.max_len + 1, framer.max_len - 1);
        send_rx_frame(total - 2, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(mbcrc_pkg::op_e'($urandom_range(1)), 8'($urandom),
                    1'($urandom_range(1)));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset length limit, no idling
    send_word(mbcrc_pkg::OP_TX, 8'h00, 1'b1);   // single-byte transmit frame
    send_word(mbcrc_pkg::OP_TX, 8'hFF, 1'b0);
    send_word(mbcrc_pkg::OP_TX, 8'h80, 1'b0);
    send_word(mbcrc_pkg::OP_TX, 8'h01, 1'b1);
    send_word(mbcrc_pkg::OP_RX, 8'h5A, 1'b1);   // too short
    send_rx_frame(0, 1'b0);                     // empty payload: FF FF checks ok
    send_rx_frame(2, 1'b0);                     // good check
    send_rx_frame(2, 1'b1);                     // damaged frame
    // transmit word inside a receive frame shares the CRC register
    send_word(mbcrc_pkg::OP_RX, 8'h11, 1'b0);
    send_word(mbcrc_pkg::OP_TX, 8'hAA, 1'b0);
    send_word(mbcrc_pkg::OP_RX, 8'h22, 1'b1);

    // Smallest limit: two bytes still pass, three overflow
    write_max_len(8'd3);
    send_rx_frame(0, 1'b0);
    send_rx_frame(1, 1'b0);

    // Largest limit: a long frame saturates the byte count and overflows
    write_max_len(8'd255);
    send_rx_frame(256, 1'b0);
    run_random(PhaseWords);

    // Sender idles often
    write_max_len(8'd3);
    send_idle_pct = 61;
    run_random(PhaseWords);

    // Receiver stalls often
    write_max_len(8'($urandom_range(20, 4)));
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    run_random(PhaseWords);

    // Both idle; long receiver hold-off fills the block, then a full drain
    write_max_len(mbcrc_pkg::FrameLenRst);
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    hold_req       = 1'b1;
    run_random(PhaseWords / 2);
    wait_drain();
    run_random(PhaseWords / 2);

    // No idling at a random limit
    write_max_len(8'($urandom_range(255, 3)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PhaseWords);

    // Receiver stalls with a tight limit and a second hold-off
    write_max_len(8'd6);
    recv_stall_pct = 61;
    hold_req       = 1'b1;
    run_random(PhaseWords);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (framer.errors == 0 && framer.pending() == 0) begin
      $display("[modbus_frame_crc_append_check] OK");
    end else begin
      $display("[modbus_frame_crc_append_check] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mbcrc_pkg.sv
design/mbcrc_core.sv
design/mbcrc_out.sv
design/modbus_frame_crc_append_check.sv
tb/sv/modbus_frame_crc_append_check_tb.sv
